@@ src/mxnl_pkg.sv @@
// ---------------------------------------------------------------------------
// mxnl_pkg
// Shared types and codes for the nearest-by-XOR key lookup block.
// ---------------------------------------------------------------------------
`default_nettype none

package mxnl_pkg;

   // Fixed field widths of the request and response words
   localparam int VALUE_W = 30;
   localparam int INDEX_W = 10;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [INDEX_W-1:0] index_type;

   // Request operation codes
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

endpackage : mxnl_pkg

`default_nettype wire

@@ src/mxnl_if.sv @@
// ---------------------------------------------------------------------------
// mxnl_if
// Valid/ready channels for the lookup block: request word and response word.
// ---------------------------------------------------------------------------
`default_nettype none

interface mxnl_req_if import mxnl_pkg::*; ();
   logic      valid;
   logic      ready;
   op_type    op;
   value_type value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface : mxnl_req_if

interface mxnl_rsp_if import mxnl_pkg::*; ();
   logic      valid;
   logic      ready;
   index_type best_index;
   logic      empty_res;

   modport source (output valid, output best_index, output empty_res, input ready);
   modport sink   (input valid, input best_index, input empty_res, output ready);
endinterface : mxnl_rsp_if

`default_nettype wire

@@ src/min_xor_nearest_lookup.sv @@
// ---------------------------------------------------------------------------
// min_xor_nearest_lookup
// Nearest-by-XOR key lookup built on a binary trie held in one RAM.
// ---------------------------------------------------------------------------
// Load words store keys of KEY_BITS bits in a binary trie, one node per key
// bit, allocated from a free counter so the RAM needs no clearing pass after
// reset; the key's load order number sits in its leaf, and a repeated key
// keeps the leaf of its first load. Loads past CAPACITY are dropped. A query
// word is XORed into the running key, which then walks the trie from the top
// bit down, taking the matching branch where it exists and the other one
// otherwise; the leaf it reaches gives the index. The key is shifted out one
// bit per cycle and the walk does one trie RAM access per bit; a query waits
// in its emit step while the previous response still sits in the output
// register. One word is in work at a time; a query on an empty store returns
// empty_res set and index zero.
// ---------------------------------------------------------------------------
`default_nettype none

module min_xor_nearest_lookup import mxnl_pkg::*; #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 30
) (
   input wire logic  clock,
   input wire logic  reset,
   mxnl_req_if.sink   req_chan,
   mxnl_rsp_if.source rsp_chan
);

   // Trie geometry
   localparam int NODES  = CAPACITY * KEY_BITS + 1;
   localparam int PTR_W  = $clog2(NODES);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int LVL_W  = $clog2(KEY_BITS + 1);
   localparam int NODE_W = 2 * PTR_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LWALK = 5'b00010,
      ST_LFILL = 5'b00100,
      ST_QWALK = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PTR_W-1:0]      free_ff, free_in;
   logic [PTR_W-1:0]      cur_ff, cur_in;
   logic [LVL_W-1:0]      level_ff, level_in;
   logic [KEY_BITS-1:0]   key_sr_ff, key_sr_in;
   logic [KEY_BITS-1:0]   run_key_ff, run_key_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      best_ff, best_in;
   logic                  empty_ff, empty_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   index_type             rsp_best_ff, rsp_best_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                  req_fire;
   logic                  key_bit;
   logic                  at_leaf;
   logic                  slot_free;
   logic                  count_full;
   logic                  count_zero;
   logic [KEY_BITS+VALUE_W-1:0] value_wide;
   logic [KEY_BITS-1:0]   value_k;
   logic [KEY_BITS-1:0]   probe;
   logic [PTR_W-1:0]      rd_c0, rd_c1;
   logic [PTR_W-1:0]      walk_child;
   logic [PTR_W-1:0]      q_pref, q_alt, q_next;
   logic [NODE_W-1:0]     leaf_word;
   logic [IDX_W+INDEX_W-1:0] best_wide;

   logic                  rd_en;
   logic [PTR_W-1:0]      rd_addr;
   logic [NODE_W-1:0]     rd_data;
   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [NODE_W-1:0]     wr_data;

   // Trie node store: child 0 in the low half, child 1 in the high half;
   // a leaf keeps its key index in the low half. Pointer zero is the root,
   // which is never a child, so zero marks a missing branch.
   mxnl_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODES)
   ) u_trie (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Decode the request word and the node being visited
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign value_wide = {{KEY_BITS{1'b0}}, req_chan.value};
   assign value_k    = value_wide[KEY_BITS-1:0];
   assign probe      = run_key_ff ^ value_k;
   assign key_bit    = key_sr_ff[KEY_BITS-1];
   assign at_leaf    = (level_ff == LVL_W'(KEY_BITS));
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign count_full = (count_ff == CNT_W'(CAPACITY));
   assign count_zero = (count_ff == '0);
   assign rd_c0      = rd_data[PTR_W-1:0];
   assign rd_c1      = rd_data[NODE_W-1:PTR_W];
   assign walk_child = key_bit ? rd_c1 : rd_c0;
   assign q_pref     = key_bit ? rd_c1 : rd_c0;
   assign q_alt      = key_bit ? rd_c0 : rd_c1;
   assign q_next     = (q_pref != '0) ? q_pref : q_alt;
   assign leaf_word  = {{(NODE_W-IDX_W){1'b0}}, idx_ff};
   assign best_wide  = {{INDEX_W{1'b0}}, best_ff};

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Sequence one word: a load walks existing nodes, then allocates fresh ones; a query walks to a leaf and emits
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      free_in    = free_ff;
      cur_in     = cur_ff;
      level_in   = level_ff;
      key_sr_in  = key_sr_ff;
      run_key_in = run_key_ff;
      idx_in     = idx_ff;
      best_in    = best_ff;
      empty_in   = empty_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = cur_ff;
      wr_data    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_in   = '0;
               level_in = '0;
               if (req_chan.op == OP_LOAD) begin
                  if (!count_full) begin
                     idx_in    = count_ff[IDX_W-1:0];
                     count_in  = count_ff + 1'b1;
                     key_sr_in = value_k;
                     if (count_zero) begin
                        state_in = ST_LFILL;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_LWALK;
                     end
                  end
               end else begin
                  run_key_in = probe;
                  key_sr_in  = probe;
                  if (count_zero) begin
                     best_in  = '0;
                     empty_in = 1'b1;
                     state_in = ST_EMIT;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = ST_QWALK;
                  end
               end
            end
         end
         ST_LWALK: begin
            if (at_leaf) begin
               // key already stored: first load keeps the leaf
               state_in = ST_IDLE;
            end else if (walk_child != '0) begin
               rd_en     = 1'b1;
               rd_addr   = walk_child;
               cur_in    = walk_child;
               key_sr_in = {key_sr_ff[KEY_BITS-2:0], 1'b0};
               level_in  = level_ff + 1'b1;
            end else begin
               // branch missing: hook a fresh node onto this one
               wr_en     = 1'b1;
               wr_data   = key_bit ? {free_ff, rd_c0} : {rd_c1, free_ff};
               cur_in    = free_ff;
               free_in   = free_ff + 1'b1;
               key_sr_in = {key_sr_ff[KEY_BITS-2:0], 1'b0};
               level_in  = level_ff + 1'b1;
               state_in  = ST_LFILL;
            end
         end
         ST_LFILL: begin
            wr_en = 1'b1;
            if (at_leaf) begin
               wr_data  = leaf_word;
               state_in = ST_IDLE;
            end else begin
               wr_data   = key_bit ? {free_ff, {PTR_W{1'b0}}} : {{PTR_W{1'b0}}, free_ff};
               cur_in    = free_ff;
               free_in   = free_ff + 1'b1;
               key_sr_in = {key_sr_ff[KEY_BITS-2:0], 1'b0};
               level_in  = level_ff + 1'b1;
            end
         end
         ST_QWALK: begin
            if (at_leaf) begin
               best_in  = rd_data[IDX_W-1:0];
               empty_in = 1'b0;
               state_in = ST_EMIT;
            end else begin
               // prefer the branch that matches, else take the other
               rd_en     = 1'b1;
               rd_addr   = q_next;
               cur_in    = q_next;
               key_sr_in = {key_sr_ff[KEY_BITS-2:0], 1'b0};
               level_in  = level_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: drop on take, load from the emit step
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_best_in  = rsp_best_ff;
      rsp_empty_in = rsp_empty_ff;
      if ((state_ff == ST_EMIT) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_best_in  = best_wide[INDEX_W-1:0];
         rsp_empty_in = empty_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.best_index = rsp_best_ff;
   assign rsp_chan.empty_res  = rsp_empty_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         free_ff      <= PTR_W'(1);
         run_key_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         run_key_ff   <= run_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk payload
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      level_ff     <= level_in;
      key_sr_ff    <= key_sr_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      empty_ff     <= empty_in;
      rsp_best_ff  <= rsp_best_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // Checks
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LWALK || state_ff == ST_LFILL || state_ff == ST_QWALK)
      |-> (level_ff <= LVL_W'(KEY_BITS)))
      else $error("trie walk went below the leaf level");

   a_fill_newest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LFILL) |-> ((cur_ff + 1'b1) == free_ff))
      else $error("fresh node is not the most recently allocated one");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("key count exceeds capacity");

   a_leaf_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QWALK && at_leaf) |=> (state_ff == ST_EMIT))
      else $error("query reached a leaf without emitting");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside the emit step");

endmodule : min_xor_nearest_lookup

`default_nettype wire

@@ src/mxnl_ram.sv @@
// ---------------------------------------------------------------------------
// mxnl_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mxnl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, hold data when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : mxnl_ram

`default_nettype wire
